### src/mbsd_pkg.sv
// Package for the monitor block status and sample decoder.
// Holds sample geometry, spike limit reset, marker masks and the status struct.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package mbsd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int LANES       = 4;
  localparam int BYTE_BITS   = 8;
  localparam int WAVE_BYTES  = 5;
  localparam int WAVE_BITS   = WAVE_BYTES * BYTE_BITS;
  localparam int CNT_BITS    = 32;

  localparam int IN_DATA_BITS  = BYTE_BITS + WAVE_BITS;
  localparam int OUT_USED_BITS = LANES * SAMPLE_BITS + 4 * CNT_BITS + 2;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  localparam logic [SAMPLE_BITS-1:0] SPIKE_RESET = SAMPLE_BITS'(1000);

  localparam int MARKER_BITS = 4;
  localparam int MARKER_LSB  = 1;
  localparam int WARN_BIT    = 5;
  localparam int CRISIS_BIT  = 6;

  localparam logic [MARKER_BITS-1:0] QRS_MASK    = 4'h3;
  localparam logic [MARKER_BITS-1:0] BREATH_MASK = 4'hc;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                crisis_now;
    logic                warning_now;
    logic [CNT_BITS-1:0] crisis_total;
    logic [CNT_BITS-1:0] warning_total;
    logic [CNT_BITS-1:0] breath_total;
    logic [CNT_BITS-1:0] qrs_total;
  } stat_t;

endpackage

### src/mbsd_lane.sv
// One sample lane: halves a sample that lies above the spike limit.
// Depends on mbsd_pkg for the sample type.
`timescale 1ns / 1ps

module mbsd_lane (
  input  mbsd_pkg::sample_t raw,
  input  mbsd_pkg::sample_t spike_limit,
  output mbsd_pkg::sample_t sample
);

  assign sample = (raw > spike_limit) ? (raw >> 1) : raw;

endmodule

### src/mbsd_status.sv
// Status tracker: marker history, priming flag and the four event counters.
// Depends on mbsd_pkg for field positions and the stat_t struct.
`timescale 1ns / 1ps

module mbsd_status (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [mbsd_pkg::BYTE_BITS-1:0]      status_byte,
  output mbsd_pkg::stat_t                     stat_nxt
);

  logic [mbsd_pkg::MARKER_BITS-1:0] prev_markers_r;
  logic                             primed_r;
  logic [mbsd_pkg::CNT_BITS-1:0]    qrs_r;
  logic [mbsd_pkg::CNT_BITS-1:0]    breath_r;
  logic [mbsd_pkg::CNT_BITS-1:0]    warn_r;
  logic [mbsd_pkg::CNT_BITS-1:0]    cris_r;

  logic [mbsd_pkg::MARKER_BITS-1:0] markers;
  logic                             warn;
  logic                             cris;
  logic                             qrs_hit;
  logic                             breath_hit;

  assign markers = status_byte[mbsd_pkg::MARKER_LSB +: mbsd_pkg::MARKER_BITS];
  assign warn    = status_byte[mbsd_pkg::WARN_BIT];
  assign cris    = status_byte[mbsd_pkg::CRISIS_BIT];

  assign qrs_hit    = primed_r &&
                      ((markers & mbsd_pkg::QRS_MASK) != (prev_markers_r & mbsd_pkg::QRS_MASK));
  assign breath_hit = primed_r &&
                      ((markers & mbsd_pkg::BREATH_MASK) !=
                       (prev_markers_r & mbsd_pkg::BREATH_MASK));

  always_comb begin
    stat_nxt.qrs_total     = qrs_r + mbsd_pkg::CNT_BITS'(qrs_hit);
    stat_nxt.breath_total  = breath_r + mbsd_pkg::CNT_BITS'(breath_hit);
    stat_nxt.warning_total = warn_r + mbsd_pkg::CNT_BITS'(warn);
    stat_nxt.crisis_total  = cris_r + mbsd_pkg::CNT_BITS'(cris);
    stat_nxt.warning_now   = warn;
    stat_nxt.crisis_now    = cris;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_markers_r <= '0;
      primed_r       <= 1'b0;
      qrs_r          <= '0;
      breath_r       <= '0;
      warn_r         <= '0;
      cris_r         <= '0;
    end else if (accept) begin
      prev_markers_r <= markers;
      primed_r       <= 1'b1;
      qrs_r          <= stat_nxt.qrs_total;
      breath_r       <= stat_nxt.breath_total;
      warn_r         <= stat_nxt.warning_total;
      cris_r         <= stat_nxt.crisis_total;
    end
  end

`ifndef SYNTH
  a_hold_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(qrs_r) && $stable(breath_r) && $stable(warn_r) && $stable(cris_r))
    else $error("counters moved without a beat");

  a_primed : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> primed_r)
    else $error("primed flag not set after a beat");

  a_first_block : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !primed_r |=> qrs_r == $past(qrs_r) && breath_r == $past(breath_r))
    else $error("marker event counted on the first block");

  a_warn_step : assert property (@(posedge clk) disable iff (!rst_n)
    accept && status_byte[mbsd_pkg::WARN_BIT] |=> warn_r == $past(warn_r) + 32'd1)
    else $error("warning counter did not advance");
`endif

endmodule

### src/monitor_block_status_and_sample_decoder.sv
// Top level of the monitor block status and sample decoder.
// Instantiates four mbsd_lane copies and mbsd_status; uses mbsd_pkg.
//
// channel  dir  handshake           payload
// in_      in   in_tvalid/tready    in_tdata[47:0]   status byte, wave bytes 0..4
// out_     out  out_tvalid/tready   out_tdata[175:0] samples 0..3, four totals, flags
// cfg_     in   cfg_valid/ready     cfg_data[9:0]    spike limit
//
// One beat per cycle in and out unless out_tready stalls; results show the cycle after.
// The four sample lanes and the counter update are combinational before the output register.
// Reset is synchronous; the spike limit returns to 1000, counters to zero.
// A stalled output register holds its beat and accepts the next one as it drains.
`timescale 1ns / 1ps

module monitor_block_status_and_sample_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // status_byte[7:0], wave_byte_0[15:8], wave_byte_1[23:16], wave_byte_2[31:24],
  // wave_byte_3[39:32], wave_byte_4[47:40]
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sample_0[9:0], sample_1[19:10], sample_2[29:20], sample_3[39:30],
  // qrs_total[71:40], breath_total[103:72], warning_total[135:104],
  // crisis_total[167:136], warning_now[168], crisis_now[169], zero[175:170]
  output logic [175:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [9:0]   cfg_data
);

  localparam int SB = mbsd_pkg::SAMPLE_BITS;
  localparam int LN = mbsd_pkg::LANES;
  localparam int WB = mbsd_pkg::WAVE_BITS;
  localparam int BB = mbsd_pkg::BYTE_BITS;

  mbsd_pkg::sample_t spike_limit_r;
  logic              out_valid_r;
  mbsd_pkg::sample_t samples_r [LN];
  mbsd_pkg::stat_t   stat_r;

  logic              accept;
  logic [WB-1:0]     wave;
  mbsd_pkg::sample_t raw    [LN];
  mbsd_pkg::sample_t sample [LN];
  mbsd_pkg::stat_t   stat_nxt;

  assign in_tready = rst_n & (~out_valid_r | out_tready);
  assign accept    = in_tvalid & in_tready;
  assign cfg_ready = rst_n;

  genvar k;
  generate
    for (k = 0; k < mbsd_pkg::WAVE_BYTES; k++) begin : g_byte
      assign wave[WB - 1 - k*BB -: BB] = in_tdata[BB*(k+1) +: BB];
    end
    for (k = 0; k < LN; k++) begin : g_lane
      assign raw[k] = wave[WB - 1 - k*SB -: SB];
      mbsd_lane u_lane (
        .raw         (raw[k]),
        .spike_limit (spike_limit_r),
        .sample      (sample[k])
      );
    end
  endgenerate

  mbsd_status u_status (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .status_byte (in_tdata[BB-1:0]),
    .stat_nxt    (stat_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spike_limit_r <= mbsd_pkg::SPIKE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        spike_limit_r <= cfg_data;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < LN; i++) begin
        samples_r[i] <= sample[i];
      end
      stat_r <= stat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    (mbsd_pkg::OUT_DATA_BITS - mbsd_pkg::OUT_USED_BITS)'(0),
    stat_r.crisis_now,
    stat_r.warning_now,
    stat_r.crisis_total,
    stat_r.warning_total,
    stat_r.breath_total,
    stat_r.qrs_total,
    samples_r[3],
    samples_r[2],
    samples_r[1],
    samples_r[0]
  };

endmodule
